FILE: src/rdpc_pkg.sv
// rdpc_pkg: command codes, register map, reset values and arithmetic constants
// shared by the remote drive pi controller rtl; no dependencies
`default_nettype none

package rdpc_pkg;

  // command codes carried in op
  localparam logic [7:0] OP_LEFT  = 8'd0;
  localparam logic [7:0] OP_RIGHT = 8'd1;
  localparam logic [7:0] OP_SPEED = 8'd2;
  localparam logic [7:0] OP_STEER = 8'd3;
  localparam logic [7:0] OP_DIR   = 8'd4;
  localparam logic [7:0] OP_HORN  = 8'd5;
  localparam logic [7:0] OP_NONE  = 8'd255;

  // horn command codes
  localparam logic [1:0] HORN_NOP   = 2'd0;
  localparam logic [1:0] HORN_START = 2'd1;
  localparam logic [1:0] HORN_STOP  = 2'd2;

  // register map, word index into apb space
  localparam int unsigned AddrW = 5;
  localparam logic [2:0] REG_DUTY_LIMIT   = 3'd0;
  localparam logic [2:0] REG_BRAKE_MARGIN = 3'd1;
  localparam logic [2:0] REG_DRIVE_MIN    = 3'd2;
  localparam logic [2:0] REG_SERVO_MIN    = 3'd3;
  localparam logic [2:0] REG_SERVO_MAX    = 3'd4;
  localparam logic [2:0] REG_HORN_PERIOD  = 3'd5;

  // register reset values
  localparam logic [15:0] DUTY_LIMIT_RST   = 16'd39990;
  localparam logic [15:0] BRAKE_MARGIN_RST = 16'd25;
  localparam logic [15:0] DRIVE_MIN_RST    = 16'd5000;
  localparam logic [15:0] SERVO_MIN_RST    = 16'd1000;
  localparam logic [15:0] SERVO_MAX_RST    = 16'd3100;
  localparam logic [31:0] HORN_PERIOD_RST  = 32'd4000;

  // reciprocal of ten: (x * 0xcccd) >> 19 is exact for any 16-bit x
  localparam logic [15:0] RECIP_TEN = 16'hCCCD;
  localparam int unsigned RECIP_SHIFT = 19;

endpackage

`default_nettype wire

FILE: src/remote_drive_pi_controller_top.sv
// remote_drive_pi_controller_top: command decode, pi speed loop, lamps and apb registers
// depends on rdpc_pkg
`default_nettype none

// One command item is taken per clock cycle and its result item appears in
// the output register in the cycle after; the pi loop state (last drive and
// integral sum) is updated in the same cycle the item is accepted, so the
// feedback path is a single pass of the error subtract and magnitude, one
// 16x16 reciprocal multiply, the integral and drive adds and three clamps.
// Input ready stays high while the output register is empty or being drained,
// giving one item per cycle sustained. Registers are written by an apb access
// and must only be written while no item is in flight.
module remote_drive_pi_controller_top
  import rdpc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // apb configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrW-1:0]    paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  // input item channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          op_i,
  input  wire logic signed [16:0]  int_value_i,
  input  wire logic [15:0]         speed_value_i,
  input  wire logic                light_phase_i,
  // result item channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [15:0]              motor_duty_o,
  output logic                     steer_write_o,
  output logic [15:0]              steer_duty_o,
  output logic                     reverse_dir_o,
  output logic                     left_lamp_o,
  output logic                     right_lamp_o,
  output logic                     indicator_led_o,
  output logic [1:0]               horn_cmd_o,
  output logic [31:0]              horn_tone_o,
  output logic                     brake_lamps_o
);

  // configuration registers
  logic [15:0] duty_limit_q, brake_margin_q, drive_min_q, servo_min_q, servo_max_q;
  logic [31:0] horn_period_q;
  logic [2:0]  reg_idx;
  logic        cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_limit_q   <= DUTY_LIMIT_RST;
      brake_margin_q <= BRAKE_MARGIN_RST;
      drive_min_q    <= DRIVE_MIN_RST;
      servo_min_q    <= SERVO_MIN_RST;
      servo_max_q    <= SERVO_MAX_RST;
      horn_period_q  <= HORN_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_DUTY_LIMIT:   duty_limit_q   <= pwdata[15:0];
        REG_BRAKE_MARGIN: brake_margin_q <= pwdata[15:0];
        REG_DRIVE_MIN:    drive_min_q    <= pwdata[15:0];
        REG_SERVO_MIN:    servo_min_q    <= pwdata[15:0];
        REG_SERVO_MAX:    servo_max_q    <= pwdata[15:0];
        REG_HORN_PERIOD:  horn_period_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (reg_idx)
      REG_DUTY_LIMIT:   prdata = {16'd0, duty_limit_q};
      REG_BRAKE_MARGIN: prdata = {16'd0, brake_margin_q};
      REG_DRIVE_MIN:    prdata = {16'd0, drive_min_q};
      REG_SERVO_MIN:    prdata = {16'd0, servo_min_q};
      REG_SERVO_MAX:    prdata = {16'd0, servo_max_q};
      REG_HORN_PERIOD:  prdata = horn_period_q;
      default:          prdata = 32'd0;
    endcase
  end

  // loop and lamp state
  logic [15:0] speed_target_q, speed_target_d;
  logic [15:0] last_drive_q, last_drive_d;
  logic [15:0] integral_q, integral_d;
  logic left_en_q, left_en_d, right_en_q, right_en_d, backwards_q, backwards_d;
  logic left_lvl_q, left_lvl_d, right_lvl_q, right_lvl_d, led_lvl_q, led_lvl_d;

  // output register
  logic        out_valid_q;
  logic        accept;
  logic        steer_w_d;
  logic [15:0] steer_d_d;
  logic [1:0]  horn_c_d;
  logic [31:0] horn_t_d;
  logic        brake_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // command decode
  logic flag;
  assign flag = (int_value_i != 17'sd0);

  always_comb begin
    speed_target_d = speed_target_q;
    left_en_d      = left_en_q;
    right_en_d     = right_en_q;
    backwards_d    = backwards_q;
    steer_w_d      = 1'b0;
    steer_d_d      = 16'd0;
    horn_c_d       = HORN_NOP;
    horn_t_d       = 32'd0;
    unique case (op_i)
      OP_LEFT:  left_en_d = flag;
      OP_RIGHT: right_en_d = flag;
      OP_SPEED: speed_target_d = speed_value_i;
      OP_STEER: begin
        steer_w_d = 1'b1;
        if ($signed({int_value_i[16], int_value_i}) < $signed({2'b00, servo_min_q})) begin
          steer_d_d = servo_min_q;
        end else if ($signed({int_value_i[16], int_value_i}) >
                     $signed({2'b00, servo_max_q})) begin
          steer_d_d = servo_max_q;
        end else begin
          steer_d_d = int_value_i[15:0];
        end
      end
      OP_DIR:   backwards_d = flag;
      OP_HORN: begin
        if (flag) begin
          horn_c_d = HORN_START;
          horn_t_d = horn_period_q;
        end else begin
          horn_c_d = HORN_STOP;
        end
      end
      OP_NONE:  ;
      default:  ;
    endcase
  end

  // turn lamps hold while their enable is off
  always_comb begin
    left_lvl_d  = left_lvl_q;
    right_lvl_d = right_lvl_q;
    led_lvl_d   = led_lvl_q;
    if (left_en_d) begin
      left_lvl_d = light_phase_i;
      led_lvl_d  = light_phase_i;
    end
    if (right_en_d) begin
      right_lvl_d = light_phase_i;
      led_lvl_d   = light_phase_i;
    end
  end

  // error and its magnitude
  logic signed [17:0] err;
  logic               err_neg;
  logic [17:0]        err_abs;
  logic [31:0]        prod;
  logic [12:0]        q10;
  logic [11:0]        q20;

  assign err     = $signed({2'b00, speed_target_d}) - $signed({2'b00, last_drive_q});
  assign err_neg = err[17];
  assign err_abs = err_neg ? 18'(-err) : 18'(err);
  // truncating divide by ten and twenty on the magnitude
  assign prod    = err_abs[15:0] * RECIP_TEN;
  assign q10     = prod[31:RECIP_SHIFT];
  assign q20     = q10[12:1];

  // pi terms with clamps
  logic [15:0]        p_term;
  logic signed [17:0] i_delta, i_sum;
  logic [16:0]        u_sum;

  always_comb begin
    // proportional: negative error clamps to zero
    if (err_neg) begin
      p_term = 16'd0;
    end else if ({3'd0, q10} > duty_limit_q) begin
      p_term = duty_limit_q;
    end else begin
      p_term = {3'd0, q10};
    end
    // integral
    i_delta = err_neg ? -$signed({6'd0, q20}) : $signed({6'd0, q20});
    i_sum   = $signed({2'b00, integral_q}) + i_delta;
    if (i_sum < 18'sd0) begin
      integral_d = 16'd0;
    end else if (i_sum > $signed({2'b00, duty_limit_q})) begin
      integral_d = duty_limit_q;
    end else begin
      integral_d = i_sum[15:0];
    end
    // drive
    u_sum = {1'b0, p_term} + {1'b0, integral_d};
    if (u_sum > {1'b0, duty_limit_q}) begin
      last_drive_d = duty_limit_q;
    end else begin
      last_drive_d = u_sum[15:0];
    end
  end

  // brake lamps
  logic signed [17:0] err_margin;
  assign err_margin = err + $signed({2'b00, brake_margin_q});
  assign brake_d    = err_margin[17] || backwards_d || (speed_target_d < drive_min_q);

  // state update on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_target_q <= 16'd0;
      last_drive_q   <= 16'd0;
      integral_q     <= 16'd0;
      left_en_q      <= 1'b0;
      right_en_q     <= 1'b0;
      backwards_q    <= 1'b0;
      left_lvl_q     <= 1'b0;
      right_lvl_q    <= 1'b0;
      led_lvl_q      <= 1'b0;
    end else if (accept) begin
      speed_target_q <= speed_target_d;
      last_drive_q   <= last_drive_d;
      integral_q     <= integral_d;
      left_en_q      <= left_en_d;
      right_en_q     <= right_en_d;
      backwards_q    <= backwards_d;
      left_lvl_q     <= left_lvl_d;
      right_lvl_q    <= right_lvl_d;
      led_lvl_q      <= led_lvl_d;
    end
  end

  // result item valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      motor_duty_o    <= last_drive_d;
      steer_write_o   <= steer_w_d;
      steer_duty_o    <= steer_d_d;
      reverse_dir_o   <= backwards_d;
      left_lamp_o     <= left_lvl_d;
      right_lamp_o    <= right_lvl_d;
      indicator_led_o <= led_lvl_d;
      horn_cmd_o      <= horn_c_d;
      horn_tone_o     <= horn_t_d;
      brake_lamps_o   <= brake_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
